/* rtl/cpt_pkg.sv */
// shared constants, types and helpers of the clarke/park transform unit
package cpt_pkg;

   localparam int CORDIC_STEPS_DEF  = 16;
   localparam int ADC_BITS_DEF      = 12;
   localparam int POSITION_BITS_DEF = 16;

   localparam int PHASE_BITS     = 16;
   localparam int DATA_BITS      = 32;
   localparam int TRIG_BITS      = 16;
   localparam int CORDIC_BITS    = 34;
   localparam int ATAN_COUNT     = 24;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAGNETIC_STEPS = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CURRENT_GAIN   = 1'b1;

   // codes of the mode field
   localparam logic MODE_FORWARD = 1'b0;
   localparam logic MODE_INVERSE = 1'b1;

   localparam logic [PHASE_BITS-1:0] MAGNETIC_STEPS_RESET = 16'd2000;
   localparam logic [DATA_BITS-1:0]  CURRENT_GAIN_RESET   = 32'd251777;

   localparam logic signed [CORDIC_BITS-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [DATA_BITS-1:0]   CLARKE_C1   = 32'sd619924842;
   localparam logic signed [DATA_BITS-1:0]   CLARKE_C2   = 32'sd1239849684;

   // arctangent of 2^-i in units of 2^-32 turn
   localparam logic [29:0] ATAN_TURN [ATAN_COUNT] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
      30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
   };

   typedef struct packed {
      logic signed [CORDIC_BITS-1:0] x;
      logic signed [CORDIC_BITS-1:0] y;
      logic signed [CORDIC_BITS-1:0] z;
      logic                          flip;
      logic [PHASE_BITS-1:0]         phase;
   } rot_type;

   typedef struct packed {
      logic                        mode;
      logic signed [DATA_BITS-1:0] p0;
      logic signed [DATA_BITS-1:0] p1;
   } pay_type;

   function automatic logic signed [DATA_BITS-1:0] sat32(input logic signed [65:0] v);
      logic signed [DATA_BITS-1:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[DATA_BITS-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [TRIG_BITS-1:0] sat16(input logic signed [CORDIC_BITS-1:0] v);
      logic signed [TRIG_BITS-1:0] r;
      if (v > 34'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -34'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[TRIG_BITS-1:0];
      end
      return r;
   endfunction

   // (a +/- b) rounded half up from q15 and saturated
   function automatic logic signed [DATA_BITS-1:0] round_q15(input logic signed [47:0] a,
                                                             input logic signed [47:0] b,
                                                             input logic neg);
      logic signed [65:0] sum;
      sum = 66'(a) + (neg ? -66'(b) : 66'(b)) + 66'sd16384;
      return sat32(sum >>> 15);
   endfunction

endpackage

/* rtl/cpt_div_cell.sv */
// one restoring long-division cell: one quotient bit per cycle
module cpt_div_cell import cpt_pkg::*; #(
   parameter int NUM_BITS = POSITION_BITS_DEF + PHASE_BITS
) (
   input  logic                  clock,
   input  logic [PHASE_BITS-1:0] steps,
   input  logic [PHASE_BITS-1:0] prev_rem,
   input  logic [NUM_BITS-1:0]   prev_num,
   input  logic [PHASE_BITS-1:0] prev_quo,
   output logic [PHASE_BITS-1:0] rem,
   output logic [NUM_BITS-1:0]   num,
   output logic [PHASE_BITS-1:0] quo
);

   logic [PHASE_BITS:0]   trial;
   logic                  take;
   logic [PHASE_BITS-1:0] rem_in, rem_ff, quo_in, quo_ff;
   logic [NUM_BITS-1:0]   num_in, num_ff;

   always_comb begin
      trial  = {prev_rem, prev_num[NUM_BITS-1]};
      take   = trial >= {1'b0, steps};
      rem_in = take ? PHASE_BITS'(trial - {1'b0, steps}) : trial[PHASE_BITS-1:0];
      num_in = {prev_num[NUM_BITS-2:0], 1'b0};
      quo_in = {prev_quo[PHASE_BITS-2:0], take};
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign rem = rem_ff;
   assign num = num_ff;
   assign quo = quo_ff;

endmodule

/* rtl/cpt_cordic_cell.sv */
// one rotation-mode cordic micro-rotation with a fixed shift
module cpt_cordic_cell import cpt_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic    clock,
   input  rot_type prev,
   output rot_type cur
);

   localparam logic signed [CORDIC_BITS-1:0] ATAN =
      $signed({{(CORDIC_BITS-30){1'b0}}, ATAN_TURN[STEP]});

   rot_type                       cur_in, cur_ff;
   logic signed [CORDIC_BITS-1:0] dx, dy;

   always_comb begin
      dx = prev.y >>> STEP;
      dy = prev.x >>> STEP;
      cur_in = prev;
      if (!prev.z[CORDIC_BITS-1]) begin
         cur_in.x = prev.x - dx;
         cur_in.y = prev.y + dy;
         cur_in.z = prev.z - ATAN;
      end else begin
         cur_in.x = prev.x + dx;
         cur_in.y = prev.y - dy;
         cur_in.z = prev.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign cur = cur_ff;

endmodule

/* rtl/clarke_park_transform_unit.sv */
// top level of the clarke/park transform unit
//
// usage
// - an item is taken at a rising edge with start high and busy low; busy is
//   always low, so one item can enter in every cycle
// - mode 0: adc readings are scaled by current_gain into q8.24 currents, then
//   clarke and park give alpha, beta, d and q
// - mode 1: inverse park of volt_d/volt_q gives alpha and beta, d and q echo
// - angle comes from rotor_position mod magnetic_steps through a chain of
//   POSITION_BITS + 16 division cells, then a chain of CORDIC_STEPS cordic cells
// - rsp_valid is high for one cycle once the item has passed the division
//   chain, the fold register, the cordic chain and the output registers
// - throughput: one item per cycle, every cell moves its data on each clock
// - the receiver cannot stall: each result shows for exactly one cycle
// - reset clears the item valid line and loads the register reset values;
//   items in flight are dropped
// - csr writes land at once; write only while no item is in flight
module clarke_park_transform_unit import cpt_pkg::*; #(
   parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
   parameter int ADC_BITS      = ADC_BITS_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // input items
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_mode,
   input  logic [ADC_BITS-1:0]         req_adc_a,
   input  logic [ADC_BITS-1:0]         req_adc_b,
   input  logic [POSITION_BITS-1:0]    req_rotor_position,
   input  logic signed [DATA_BITS-1:0] req_volt_d,
   input  logic signed [DATA_BITS-1:0] req_volt_q,
   // result items
   output logic                        rsp_valid,
   output logic signed [DATA_BITS-1:0] rsp_alpha_value,
   output logic signed [DATA_BITS-1:0] rsp_beta_value,
   output logic signed [DATA_BITS-1:0] rsp_d_value,
   output logic signed [DATA_BITS-1:0] rsp_q_value,
   output logic [PHASE_BITS-1:0]       rsp_angle_phase,
   // register writes
   input  logic                        csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [DATA_BITS-1:0]        csr_write_data
);

   localparam int DIV_CELLS   = POSITION_BITS + PHASE_BITS;
   localparam int SC_STAGE    = DIV_CELLS + CORDIC_STEPS + 2;   // sin/cos ready
   localparam int RSP_LATENCY = SC_STAGE + 2;
   localparam int DLY         = SC_STAGE - 4;                   // payload ready at 4
   localparam int PROD_BITS   = ADC_BITS + DATA_BITS;

   // configuration registers
   logic [PHASE_BITS-1:0] magnetic_steps_ff;
   logic [DATA_BITS-1:0]  current_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         magnetic_steps_ff <= MAGNETIC_STEPS_RESET;
         current_gain_ff   <= CURRENT_GAIN_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAGNETIC_STEPS: magnetic_steps_ff <= csr_write_data[PHASE_BITS-1:0];
            CSR_CURRENT_GAIN:   current_gain_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // item valid line, one bit per stage
   logic                 accept;
   logic [RSP_LATENCY:0] valid_in, valid_ff;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign valid_in = {valid_ff[RSP_LATENCY-1:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage 0: input register
   logic                        mode_ff;
   logic [ADC_BITS-1:0]         adc_a_ff, adc_b_ff;
   logic [POSITION_BITS-1:0]    pos_ff;
   logic signed [DATA_BITS-1:0] vd_ff, vq_ff;

   always_ff @(posedge clock) begin
      mode_ff  <= req_mode;
      adc_a_ff <= req_adc_a;
      adc_b_ff <= req_adc_b;
      pos_ff   <= req_rotor_position;
      vd_ff    <= req_volt_d;
      vq_ff    <= req_volt_q;
   end

   // stage 1: raw current products
   logic [PROD_BITS-1:0]        prod_a_ff, prod_b_ff;
   logic                        mode1_ff;
   logic signed [DATA_BITS-1:0] vd1_ff, vq1_ff;

   always_ff @(posedge clock) begin
      prod_a_ff <= PROD_BITS'(adc_a_ff) * PROD_BITS'(current_gain_ff);
      prod_b_ff <= PROD_BITS'(adc_b_ff) * PROD_BITS'(current_gain_ff);
      mode1_ff  <= mode_ff;
      vd1_ff    <= vd_ff;
      vq1_ff    <= vq_ff;
   end

   // stage 2: round by 2^8, clamp to the positive q8.24 range
   logic [PROD_BITS:0]          rnd_a, rnd_b;
   logic signed [DATA_BITS-1:0] ia_in, ib_in, ia_ff, ib_ff;
   logic                        mode2_ff;
   logic signed [DATA_BITS-1:0] vd2_ff, vq2_ff;

   always_comb begin
      rnd_a = ({1'b0, prod_a_ff} + (PROD_BITS+1)'(128)) >> 8;
      rnd_b = ({1'b0, prod_b_ff} + (PROD_BITS+1)'(128)) >> 8;
      ia_in = (|rnd_a[PROD_BITS:DATA_BITS-1]) ? 32'sh7fffffff : $signed(rnd_a[DATA_BITS-1:0]);
      ib_in = (|rnd_b[PROD_BITS:DATA_BITS-1]) ? 32'sh7fffffff : $signed(rnd_b[DATA_BITS-1:0]);
   end

   always_ff @(posedge clock) begin
      ia_ff    <= ia_in;
      ib_ff    <= ib_in;
      mode2_ff <= mode1_ff;
      vd2_ff   <= vd1_ff;
      vq2_ff   <= vq1_ff;
   end

   // stage 3: clarke products
   logic signed [63:0]          c1_ff, c2_ff;
   logic signed [DATA_BITS-1:0] ia3_ff, vd3_ff, vq3_ff;
   logic                        mode3_ff;

   always_ff @(posedge clock) begin
      c1_ff    <= 64'(ia_ff) * 64'(CLARKE_C1);
      c2_ff    <= 64'(ib_ff) * 64'(CLARKE_C2);
      ia3_ff   <= ia_ff;
      mode3_ff <= mode2_ff;
      vd3_ff   <= vd2_ff;
      vq3_ff   <= vq2_ff;
   end

   // stage 4: beta current, pick the operand pair by mode
   logic signed [65:0] clarke_sum;
   pay_type            pay_in, pay_ff;

   always_comb begin
      clarke_sum  = 66'(c1_ff) + 66'(c2_ff) + 66'sd536870912;
      pay_in.mode = mode3_ff;
      pay_in.p0   = (mode3_ff == MODE_INVERSE) ? vd3_ff : ia3_ff;
      pay_in.p1   = (mode3_ff == MODE_INVERSE) ? vq3_ff : sat32(clarke_sum >>> 30);
   end

   always_ff @(posedge clock) begin
      pay_ff <= pay_in;
   end

   // payload delay line up to the sin/cos stage
   pay_type dl_ff [DLY];

   always_ff @(posedge clock) begin
      dl_ff[0] <= pay_ff;
      for (int k = 1; k < DLY; k++) begin
         dl_ff[k] <= dl_ff[k-1];
      end
   end

   // angle: chain of division cells over {position, 16 zero bits}
   logic [PHASE_BITS-1:0] div_rem [DIV_CELLS+1];
   logic [DIV_CELLS-1:0]  div_num [DIV_CELLS+1];
   logic [PHASE_BITS-1:0] div_quo [DIV_CELLS+1];

   assign div_rem[0] = '0;
   assign div_num[0] = {pos_ff, {PHASE_BITS{1'b0}}};
   assign div_quo[0] = '0;

   for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
      cpt_div_cell #(.NUM_BITS(DIV_CELLS)) u_cell (
         .clock    (clock),
         .steps    (magnetic_steps_ff),
         .prev_rem (div_rem[g]),
         .prev_num (div_num[g]),
         .prev_quo (div_quo[g]),
         .rem      (div_rem[g+1]),
         .num      (div_num[g+1]),
         .quo      (div_quo[g+1])
      );
   end

   // fold the angle into a quarter turn either side of zero
   logic [PHASE_BITS-1:0]         phase;
   logic signed [CORDIC_BITS-1:0] z_raw;
   rot_type                       fold_in, fold_ff;

   always_comb begin
      // zero steps: angle taken as zero
      phase        = (magnetic_steps_ff == '0) ? '0 : div_quo[DIV_CELLS];
      z_raw        = CORDIC_BITS'($signed({phase, {PHASE_BITS{1'b0}}}));
      fold_in.x     = CORDIC_GAIN;
      fold_in.y     = '0;
      fold_in.phase = phase;
      fold_in.z     = z_raw;
      fold_in.flip  = 1'b0;
      if (z_raw > 34'sd1073741824) begin
         fold_in.z    = z_raw - 34'sd2147483648;
         fold_in.flip = 1'b1;
      end else if (z_raw < -34'sd1073741824) begin
         fold_in.z    = z_raw + 34'sd2147483648;
         fold_in.flip = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      fold_ff <= fold_in;
   end

   // chain of cordic cells
   rot_type rot [CORDIC_STEPS+1];

   assign rot[0] = fold_ff;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      cpt_cordic_cell #(.STEP(g)) u_cell (
         .clock (clock),
         .prev  (rot[g]),
         .cur   (rot[g+1])
      );
   end

   // round to q1.15, undo the fold, clamp
   logic signed [CORDIC_BITS-1:0] rc, rs;
   logic signed [TRIG_BITS-1:0]   cos_ff, sin_ff;
   logic [PHASE_BITS-1:0]         phase_sc_ff;

   always_comb begin
      rc = (rot[CORDIC_STEPS].x + 34'sd16384) >>> 15;
      rs = (rot[CORDIC_STEPS].y + 34'sd16384) >>> 15;
      if (rot[CORDIC_STEPS].flip) begin
         rc = -rc;
         rs = -rs;
      end
   end

   always_ff @(posedge clock) begin
      cos_ff      <= sat16(rc);
      sin_ff      <= sat16(rs);
      phase_sc_ff <= rot[CORDIC_STEPS].phase;
   end

   // park / inverse park products
   logic signed [47:0]    m0_ff, m1_ff, m2_ff, m3_ff;
   pay_type               mix_pay_ff;
   logic [PHASE_BITS-1:0] mix_phase_ff;

   always_ff @(posedge clock) begin
      m0_ff        <= 48'(dl_ff[DLY-1].p0) * 48'(cos_ff);
      m1_ff        <= 48'(dl_ff[DLY-1].p1) * 48'(sin_ff);
      m2_ff        <= 48'(dl_ff[DLY-1].p1) * 48'(cos_ff);
      m3_ff        <= 48'(dl_ff[DLY-1].p0) * 48'(sin_ff);
      mix_pay_ff   <= dl_ff[DLY-1];
      mix_phase_ff <= phase_sc_ff;
   end

   // result register
   logic signed [DATA_BITS-1:0] alpha_ff, beta_ff, d_ff, q_ff;
   logic [PHASE_BITS-1:0]       angle_ff;

   always_ff @(posedge clock) begin
      angle_ff <= mix_phase_ff;
      if (mix_pay_ff.mode == MODE_INVERSE) begin
         alpha_ff <= round_q15(m0_ff, m1_ff, 1'b1);
         beta_ff  <= round_q15(m3_ff, m2_ff, 1'b0);
         d_ff     <= mix_pay_ff.p0;
         q_ff     <= mix_pay_ff.p1;
      end else begin
         alpha_ff <= mix_pay_ff.p0;
         beta_ff  <= mix_pay_ff.p1;
         d_ff     <= round_q15(m0_ff, m1_ff, 1'b0);
         q_ff     <= round_q15(m2_ff, m3_ff, 1'b1);
      end
   end

   assign rsp_valid       = valid_ff[RSP_LATENCY];
   assign rsp_alpha_value = alpha_ff;
   assign rsp_beta_value  = beta_ff;
   assign rsp_d_value     = d_ff;
   assign rsp_q_value     = q_ff;
   assign rsp_angle_phase = angle_ff;

endmodule

/* rtl/cpt_checker.sv */
// port-level checks of the clarke/park transform unit, bound to the top level
module cpt_checker import cpt_pkg::*; #(
   parameter int DELAY = 53
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        req_mode,
   input logic signed [DATA_BITS-1:0] req_volt_d,
   input logic signed [DATA_BITS-1:0] req_volt_q,
   input logic                        rsp_valid,
   input logic signed [DATA_BITS-1:0] rsp_d_value,
   input logic signed [DATA_BITS-1:0] rsp_q_value
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");

   // each item gives a result after the fixed latency
   a_item_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##DELAY rsp_valid)
      else $error("item without result");

   // no result without an item
   a_no_ghost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, DELAY))
      else $error("result without item");

   // inverse park items echo the voltage pair
   a_echo: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_mode, DELAY)) |->
         (rsp_d_value == $past(req_volt_d, DELAY) && rsp_q_value == $past(req_volt_q, DELAY)))
      else $error("voltage echo mismatch");

endmodule

bind clarke_park_transform_unit cpt_checker #(.DELAY(RSP_LATENCY + 1)) u_cpt_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_mode    (req_mode),
   .req_volt_d  (req_volt_d),
   .req_volt_q  (req_volt_q),
   .rsp_valid   (rsp_valid),
   .rsp_d_value (rsp_d_value),
   .rsp_q_value (rsp_q_value)
);
